// File: rtl/bces_pkg.sv
// shared types and constants for the beta execute step unit
package bces_pkg;

    localparam logic [31:0] SUP_BIT   = 32'h8000_0000;
    localparam logic [31:0] JUMP_MASK = 32'h7FFF_FFFC;
    localparam logic [31:0] PC_STEP   = 32'd4;

    localparam logic [5:0] OP_JMP     = 6'd26;
    localparam logic [5:0] OP_BT      = 6'd27;
    localparam logic [5:0] OP_BF      = 6'd28;
    localparam logic [5:0] OP_LD      = 6'd29;
    localparam logic [5:0] OP_ST      = 6'd30;
    localparam logic [5:0] OP_LDR     = 6'd31;
    localparam logic [5:0] OP_SCALL   = 6'd32;
    localparam logic [5:0] OP_ALU_END = 6'd26;

    localparam logic [3:0] ALU_ADD   = 4'd0;
    localparam logic [3:0] ALU_AND   = 4'd1;
    localparam logic [3:0] ALU_MUL   = 4'd2;
    localparam logic [3:0] ALU_DIV   = 4'd3;
    localparam logic [3:0] ALU_OR    = 4'd4;
    localparam logic [3:0] ALU_SHL   = 4'd5;
    localparam logic [3:0] ALU_SHR   = 4'd6;
    localparam logic [3:0] ALU_SRA   = 4'd7;
    localparam logic [3:0] ALU_SUB   = 4'd8;
    localparam logic [3:0] ALU_XOR   = 4'd9;
    localparam logic [3:0] ALU_CMPEQ = 4'd10;
    localparam logic [3:0] ALU_CMPLE = 4'd11;

    localparam logic [15:0] CO_HALT  = 16'd0;
    localparam logic [15:0] CO_RDCH  = 16'd1;
    localparam logic [15:0] CO_WRCH  = 16'd2;

    localparam logic [1:0] MEM_NONE  = 2'd0;
    localparam logic [1:0] MEM_READ  = 2'd1;
    localparam logic [1:0] MEM_WRITE = 2'd2;

    localparam logic [1:0] CFG_RESET_VEC = 2'd0;
    localparam logic [1:0] CFG_ILL_VEC   = 2'd1;
    localparam logic [1:0] CFG_CLK_VEC   = 2'd2;
    localparam logic [1:0] CFG_KBD_VEC   = 2'd3;

    typedef struct packed {
        logic               req_type;
        logic [5:0]         opcode;
        logic [4:0]         src_a;
        logic [4:0]         src_b;
        logic [4:0]         dest_c;
        logic signed [15:0] immediate;
        logic [31:0]        load_data;
        logic [7:0]         console_char;
        logic               clock_irq;
        logic               keyboard_irq;
    } in_item_t;

    typedef struct packed {
        logic [31:0] next_pc;
        logic        pc_valid;
        logic [1:0]  mem_request;
        logic [31:0] mem_address;
        logic [31:0] mem_write_data;
        logic        char_out_valid;
        logic [7:0]  char_out;
        logic        char_taken;
        logic        halted;
    } out_item_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ_A,
        ST_READ_B,
        ST_EXEC,
        ST_DIV,
        ST_WB,
        ST_IRQ,
        ST_CLEAR,
        ST_OUT
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic latch_item;
        logic read_a;
        logic read_b;
        logic exec;
        logic div_start;
        logic write_back;
        logic irq;
        logic clear_step;
        logic load_out;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic is_div;
        logic div_done;
        logic clear_done;
    } status_t;

endpackage

// File: rtl/bces_div.sv
// iterative signed divider, one quotient bit per cycle
module bces_div (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [31:0] divisor,
    output logic        done,
    output logic [31:0] quotient
);
    logic [31:0] rem_reg, rem_next;
    logic [31:0] quo_reg, quo_next;
    logic [31:0] dsr_reg, dsr_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        neg_reg, neg_next;
    logic        zero_reg, zero_next;
    logic        busy_reg, busy_next;
    logic [32:0] trial;
    logic [31:0] shifted;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        dsr_reg  <= dsr_next;
        neg_reg  <= neg_next;
        zero_reg <= zero_next;
    end

    always_comb begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        neg_next  = neg_reg;
        zero_next = zero_reg;
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        shifted   = {rem_reg[30:0], quo_reg[31]};
        trial     = {1'b0, shifted} - {1'b0, dsr_reg};
        if (start) begin
            rem_next  = '0;
            quo_next  = dividend[31] ? (32'd0 - dividend) : dividend;
            dsr_next  = divisor[31] ? (32'd0 - divisor) : divisor;
            neg_next  = dividend[31] ^ divisor[31];
            zero_next = (divisor == '0);
            busy_next = 1'b1;
            cnt_next  = '0;
        end else if (busy_reg) begin
            if (cnt_reg == 6'd32) begin
                // quotient settled, done is high for this one cycle
                busy_next = 1'b0;
            end else begin
                if (!trial[32]) begin
                    rem_next = trial[31:0];
                end else begin
                    rem_next = shifted;
                end
                quo_next = {quo_reg[30:0], ~trial[32]};
                cnt_next = cnt_reg + 6'd1;
            end
        end
    end

    assign done     = busy_reg && (cnt_reg == 6'd32);
    assign quotient = zero_reg ? 32'hFFFF_FFFF : (neg_reg ? (32'd0 - quo_reg) : quo_reg);
endmodule

// File: rtl/bces_ctrl.sv
// controller state machine for the execute step
module bces_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    output logic                m_valid,
    input  logic                m_ready,
    input  bces_pkg::status_t   status,
    output bces_pkg::cmd_t      cmd
);
    bces_pkg::state_t state_reg, state_next;
    logic             mv_reg, mv_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= bces_pkg::ST_CLEAR;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            mv_reg    <= mv_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        mv_next    = mv_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        if (mv_reg && m_ready) begin
            mv_next = 1'b0;
        end
        unique case (state_reg)
            bces_pkg::ST_CLEAR: begin
                cmd.clear_step = 1'b1;
                if (status.clear_done) begin
                    state_next = bces_pkg::ST_IDLE;
                end
            end
            bces_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.latch_item = 1'b1;
                    state_next     = bces_pkg::ST_READ_A;
                end
            end
            bces_pkg::ST_READ_A: begin
                cmd.read_a = 1'b1;
                state_next = bces_pkg::ST_READ_B;
            end
            bces_pkg::ST_READ_B: begin
                cmd.read_b = 1'b1;
                state_next = bces_pkg::ST_EXEC;
            end
            bces_pkg::ST_EXEC: begin
                if (status.is_div) begin
                    cmd.div_start = 1'b1;
                    state_next    = bces_pkg::ST_DIV;
                end else begin
                    cmd.exec   = 1'b1;
                    state_next = bces_pkg::ST_WB;
                end
            end
            bces_pkg::ST_DIV: begin
                if (status.div_done) begin
                    cmd.exec   = 1'b1;
                    state_next = bces_pkg::ST_WB;
                end
            end
            bces_pkg::ST_WB: begin
                cmd.write_back = 1'b1;
                state_next     = bces_pkg::ST_IRQ;
            end
            bces_pkg::ST_IRQ: begin
                cmd.irq    = 1'b1;
                state_next = bces_pkg::ST_OUT;
            end
            bces_pkg::ST_OUT: begin
                if (!mv_reg || m_ready) begin
                    cmd.load_out = 1'b1;
                    mv_next      = 1'b1;
                    state_next   = bces_pkg::ST_IDLE;
                end
            end
            default: state_next = bces_pkg::ST_IDLE;
        endcase
    end

    assign m_valid = mv_reg;
endmodule

// File: rtl/bces_dp.sv
// datapath: register file, alu, pc, flags and result register
module bces_dp #(
    parameter int EXCEPTION_REG = 30
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  bces_pkg::in_item_t   s_item,
    input  bces_pkg::cmd_t       cmd,
    output bces_pkg::status_t    status,
    input  logic                 cfg_valid,
    input  logic [1:0]           cfg_index,
    input  logic [31:0]          cfg_data,
    output bces_pkg::out_item_t  m_item
);
    localparam logic [4:0] EXC_IDX = 5'(EXCEPTION_REG);

    logic [31:0] rf_mem [32];
    logic [31:0] rd_data_reg;
    logic [4:0]  rd_addr;
    logic        wr_en;
    logic [4:0]  wr_addr;
    logic [31:0] wr_data;
    logic [4:0]  clr_cnt_reg;
    logic        clr_fin_reg;

    bces_pkg::in_item_t item_reg;
    logic [31:0] a_reg, res_reg, res_next;
    logic [31:0] pc_reg, pc_next;
    logic [31:0] old_reg;
    logic        wb_en_reg, wb_en_next;
    logic [4:0]  wb_addr_reg, wb_addr_next;
    logic [31:0] vec_reset_reg, vec_ill_reg, vec_clk_reg, vec_kbd_reg;
    logic        clk_pend_reg, halt_reg, lw_reg;
    logic [4:0]  lt_reg;
    logic        act_reg;
    logic [1:0]  mreq_reg, mreq_next;
    logic [31:0] maddr_reg, maddr_next, mdata_reg, mdata_next;
    logic        cvalid_reg, cvalid_next, ctaken_reg, ctaken_next;
    logic [7:0]  cout_reg, cout_next;
    logic        halt_next, lw_next;
    logic [4:0]  lt_next;
    logic        irq_wr;
    logic [31:0] irq_pc;
    logic        irq_clr;

    logic [31:0] opb, imm_ext, alu_out, mul_out, div_q;
    logic [3:0]  alu_k;
    logic        div_done;

    // second operand comes from the read register, or from the immediate in the constant form; nothing writes
    // the register file between its read and the execute step
    assign imm_ext = 32'(signed'(item_reg.immediate));
    assign alu_k   = item_reg.opcode[4:1];
    assign opb     = item_reg.opcode[0] ? imm_ext : rd_data_reg;
    assign mul_out = a_reg * opb;
    assign status.is_div     = (item_reg.opcode < bces_pkg::OP_ALU_END) &&
                               (alu_k == bces_pkg::ALU_DIV) && act_reg;
    assign status.div_done   = div_done;
    assign status.clear_done = clr_fin_reg;

    bces_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (a_reg),
        .divisor  (opb),
        .done     (div_done),
        .quotient (div_q)
    );

    always_comb begin
        unique case (alu_k)
            bces_pkg::ALU_ADD:   alu_out = a_reg + opb;
            bces_pkg::ALU_AND:   alu_out = a_reg & opb;
            bces_pkg::ALU_MUL:   alu_out = mul_out;
            bces_pkg::ALU_DIV:   alu_out = div_q;
            bces_pkg::ALU_OR:    alu_out = a_reg | opb;
            bces_pkg::ALU_SHL:   alu_out = a_reg << opb[4:0];
            bces_pkg::ALU_SHR:   alu_out = a_reg >> opb[4:0];
            bces_pkg::ALU_SRA:   alu_out = 32'($signed(a_reg) >>> opb[4:0]);
            bces_pkg::ALU_SUB:   alu_out = a_reg - opb;
            bces_pkg::ALU_XOR:   alu_out = a_reg ^ opb;
            bces_pkg::ALU_CMPEQ: alu_out = {31'd0, a_reg == opb};
            bces_pkg::ALU_CMPLE: alu_out = {31'd0, $signed(a_reg) <= $signed(opb)};
            default:             alu_out = {31'd0, $signed(a_reg) < $signed(opb)};
        endcase
    end

    // register file port: one read, one write per cycle
    // the callout reads register 0 as its first operand
    always_comb begin
        rd_addr = cmd.read_a ?
                  ((item_reg.opcode == bces_pkg::OP_SCALL) ? 5'd0 : item_reg.src_a) :
                  (item_reg.opcode == bces_pkg::OP_ST) ? item_reg.dest_c : item_reg.src_b;
        wr_en   = 1'b0;
        wr_addr = wb_addr_reg;
        wr_data = res_reg;
        if (cmd.clear_step) begin
            wr_en   = 1'b1;
            wr_addr = clr_cnt_reg;
            wr_data = '0;
        end else if (cmd.write_back && wb_en_reg && (wb_addr_reg != 5'd31)) begin
            wr_en = 1'b1;
        end else if (irq_wr && (EXC_IDX != 5'd31)) begin
            wr_en   = 1'b1;
            wr_addr = EXC_IDX;
            wr_data = irq_pc;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            rf_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= (rd_addr == 5'd31) ? '0 : rf_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg <= '0;
            clr_fin_reg <= 1'b0;
        end else if (cmd.clear_step) begin
            clr_cnt_reg <= clr_cnt_reg + 5'd1;
            clr_fin_reg <= (clr_cnt_reg == 5'd30);
        end
    end

    // clear the output fields on a new item; exec: compute results from registered operands
    always_comb begin
        pc_next      = pc_reg;
        res_next     = res_reg;
        wb_en_next   = wb_en_reg;
        wb_addr_next = wb_addr_reg;
        mreq_next    = mreq_reg;
        maddr_next   = maddr_reg;
        mdata_next   = mdata_reg;
        cvalid_next  = cvalid_reg;
        cout_next    = cout_reg;
        ctaken_next  = ctaken_reg;
        halt_next    = halt_reg;
        lw_next      = lw_reg;
        lt_next      = lt_reg;
        irq_wr       = 1'b0;
        irq_pc       = pc_reg + bces_pkg::PC_STEP;
        irq_clr      = 1'b0;
        if (cmd.latch_item) begin
            wb_en_next  = 1'b0;
            mreq_next   = bces_pkg::MEM_NONE;
            maddr_next  = '0;
            mdata_next  = '0;
            cvalid_next = 1'b0;
            cout_next   = '0;
            ctaken_next = 1'b0;
        end
        if (cmd.exec && act_reg) begin
            wb_addr_next = item_reg.dest_c;
            if (item_reg.req_type) begin
                wb_en_next   = 1'b1;
                wb_addr_next = lt_reg;
                res_next     = item_reg.load_data;
                lw_next      = 1'b0;
            end else begin
                pc_next = old_reg;
                if (item_reg.opcode < bces_pkg::OP_ALU_END) begin
                    wb_en_next = 1'b1;
                    res_next   = alu_out;
                end else if (item_reg.opcode == bces_pkg::OP_JMP) begin
                    wb_en_next = 1'b1;
                    res_next   = old_reg;
                    pc_next    = a_reg & (bces_pkg::JUMP_MASK | (old_reg & bces_pkg::SUP_BIT));
                end else if (item_reg.opcode == bces_pkg::OP_BT ||
                             item_reg.opcode == bces_pkg::OP_BF) begin
                    wb_en_next = 1'b1;
                    res_next   = old_reg;
                    if ((a_reg != '0) == (item_reg.opcode == bces_pkg::OP_BT)) begin
                        pc_next = (old_reg + (imm_ext << 2)) &
                                  (bces_pkg::JUMP_MASK | (old_reg & bces_pkg::SUP_BIT));
                    end
                end else if (item_reg.opcode == bces_pkg::OP_LD ||
                             item_reg.opcode == bces_pkg::OP_LDR) begin
                    mreq_next  = bces_pkg::MEM_READ;
                    maddr_next = (item_reg.opcode == bces_pkg::OP_LD) ?
                                 a_reg + imm_ext : old_reg + (imm_ext << 2);
                    lw_next    = 1'b1;
                    lt_next    = item_reg.dest_c;
                end else if (item_reg.opcode == bces_pkg::OP_ST) begin
                    mreq_next  = bces_pkg::MEM_WRITE;
                    maddr_next = a_reg + imm_ext;
                    mdata_next = rd_data_reg;
                end else if (item_reg.opcode == bces_pkg::OP_SCALL && old_reg[31]) begin
                    if (item_reg.immediate == bces_pkg::CO_HALT) begin
                        halt_next = 1'b1;
                    end else if (item_reg.immediate == bces_pkg::CO_RDCH) begin
                        wb_en_next   = 1'b1;
                        wb_addr_next = '0;
                        res_next     = {24'd0, item_reg.console_char};
                        ctaken_next  = 1'b1;
                    end else if (item_reg.immediate == bces_pkg::CO_WRCH) begin
                        cvalid_next = 1'b1;
                        cout_next   = a_reg[7:0];
                    end
                end else begin
                    wb_en_next   = 1'b1;
                    wb_addr_next = EXC_IDX;
                    res_next     = old_reg;
                    pc_next      = vec_ill_reg;
                end
            end
        end
        // interrupt check after the instruction, user mode only
        if (cmd.irq && act_reg && !lw_reg && !pc_reg[31]) begin
            if (clk_pend_reg) begin
                irq_wr  = 1'b1;
                irq_clr = 1'b1;
                pc_next = vec_clk_reg;
            end else if (item_reg.keyboard_irq) begin
                irq_wr  = 1'b1;
                pc_next = vec_kbd_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vec_reset_reg <= 32'h8000_0000;
            vec_ill_reg   <= 32'h8000_0004;
            vec_clk_reg   <= 32'h8000_0008;
            vec_kbd_reg   <= 32'h8000_000C;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                bces_pkg::CFG_RESET_VEC: vec_reset_reg <= cfg_data;
                bces_pkg::CFG_ILL_VEC:   vec_ill_reg   <= cfg_data;
                bces_pkg::CFG_CLK_VEC:   vec_clk_reg   <= cfg_data;
                default:                 vec_kbd_reg   <= cfg_data;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg       <= vec_reset_reg;
            clk_pend_reg <= 1'b0;
            halt_reg     <= 1'b0;
            lw_reg       <= 1'b0;
            lt_reg       <= '0;
            act_reg      <= 1'b0;
            wb_en_reg    <= 1'b0;
        end else begin
            pc_reg    <= pc_next;
            halt_reg  <= halt_next;
            lw_reg    <= lw_next;
            lt_reg    <= lt_next;
            wb_en_reg <= wb_en_next;
            if (cmd.latch_item) begin
                act_reg <= s_item.req_type ? lw_reg : (!lw_reg && !halt_reg);
                if (s_item.clock_irq) begin
                    clk_pend_reg <= 1'b1;
                end
            end else if (irq_clr) begin
                clk_pend_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.latch_item) begin
            item_reg <= s_item;
            old_reg  <= pc_reg + bces_pkg::PC_STEP;
        end
        if (cmd.read_b) begin
            a_reg <= rd_data_reg;
        end
        res_reg     <= res_next;
        wb_addr_reg <= wb_addr_next;
        mreq_reg    <= mreq_next;
        maddr_reg   <= maddr_next;
        mdata_reg   <= mdata_next;
        cvalid_reg  <= cvalid_next;
        cout_reg    <= cout_next;
        ctaken_reg  <= ctaken_next;
        if (cmd.load_out) begin
            m_item.next_pc        <= pc_reg;
            m_item.pc_valid       <= !lw_reg;
            m_item.mem_request    <= mreq_reg;
            m_item.mem_address    <= maddr_reg;
            m_item.mem_write_data <= mdata_reg;
            m_item.char_out_valid <= cvalid_reg;
            m_item.char_out       <= cout_reg;
            m_item.char_taken     <= ctaken_reg;
            m_item.halted         <= halt_reg;
        end
    end
endmodule

// File: rtl/beta_cpu_execute_step_unit.sv
// top level of the beta execute step unit
// One decoded instruction or load return is taken per item and gives exactly one result
// item. A plain instruction steps through register read of two operands through the single
// register file port, execute, write back, interrupt check and output load, and no new item
// is taken until that result is loaded; signed divide adds a pass through the bit-serial
// divider. A result not yet taken holds the next one in the output stage and stalls the input.
// After reset a pass clears the register file before the first item is accepted.
module beta_cpu_execute_step_unit #(
    parameter int EXCEPTION_REG = 30
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  bces_pkg::in_item_t  s_item,
    output logic                m_valid,
    input  logic                m_ready,
    output bces_pkg::out_item_t m_item,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_index,
    input  logic [31:0]         cfg_data
);
    bces_pkg::cmd_t    cmd;
    bces_pkg::status_t status;

    assign cfg_ready = 1'b1;

    bces_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    bces_dp #(.EXCEPTION_REG(EXCEPTION_REG)) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_item    (s_item),
        .cmd       (cmd),
        .status    (status),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_item    (m_item)
    );
endmodule

// File: tb/testbench.sv
// self-checking testbench for the beta execute step unit
module testbench;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    bces_pkg::in_item_t  s_item = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    bces_pkg::out_item_t m_item;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [1:0]          cfg_index = '0;
    logic [31:0]         cfg_data = '0;

    localparam int EXC_REG = 30;
    localparam int CYCLE_LIMIT = 600000;
    localparam logic [5:0] OP_ILLEGAL = 6'd63;

    beta_cpu_execute_step_unit #(.EXCEPTION_REG(EXC_REG)) dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_item(s_item),
        .m_valid(m_valid), .m_ready(m_ready), .m_item(m_item),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // predicted cpu state
    logic [31:0] gpr [32];
    logic [31:0] pc;
    logic        clk_pend, halt_f, ld_wait;
    logic [4:0]  ld_tgt;
    logic [31:0] vec_reset, vec_ill, vec_clk, vec_kbd;

    bces_pkg::out_item_t exp_results[$];
    int errors = 0;
    int cycles = 0;
    int tx_idle = 0;
    int rx_idle = 0;
    int hold_req = 0;
    int hold_seen = 0;
    int hold_left = 0;

    initial begin
        forever #6 aclk = ~aclk;
    end

    task automatic report(string what);
        $display("mismatch: %s", what);
        errors++;
    endtask

    function automatic logic [31:0] rd_reg(logic [4:0] i);
        return (i == 5'd31) ? 32'd0 : gpr[i];
    endfunction

    function automatic void wr_reg(logic [4:0] i, logic [31:0] v);
        if (i != 5'd31) gpr[i] = v;
    endfunction

    function automatic logic [5:0] alu_opcode(logic [3:0] k, logic cform);
        return {1'b0, k, cform};
    endfunction

    function automatic void take_irq(logic kbd);
        if (!pc[31]) begin
            if (clk_pend) begin
                clk_pend = 1'b0;
                wr_reg(5'(EXC_REG), pc + bces_pkg::PC_STEP);
                pc = vec_clk;
            end else if (kbd) begin
                wr_reg(5'(EXC_REG), pc + bces_pkg::PC_STEP);
                pc = vec_kbd;
            end
        end
    endfunction

    function automatic logic [31:0] alu_result(logic [3:0] k, logic [31:0] a, logic [31:0] b);
        logic [31:0] ma, mb, q;
        case (k)
            bces_pkg::ALU_ADD: return a + b;
            bces_pkg::ALU_AND: return a & b;
            bces_pkg::ALU_MUL: return a * b;
            bces_pkg::ALU_DIV: begin
                if (b == 32'd0) return 32'hFFFF_FFFF;
                ma = a[31] ? -a : a;
                mb = b[31] ? -b : b;
                q = ma / mb;
                return (a[31] ^ b[31]) ? -q : q;
            end
            bces_pkg::ALU_OR:    return a | b;
            bces_pkg::ALU_SHL:   return a << b[4:0];
            bces_pkg::ALU_SHR:   return a >> b[4:0];
            bces_pkg::ALU_SRA:   return $unsigned($signed(a) >>> b[4:0]);
            bces_pkg::ALU_SUB:   return a - b;
            bces_pkg::ALU_XOR:   return a ^ b;
            bces_pkg::ALU_CMPEQ: return {31'd0, a == b};
            bces_pkg::ALU_CMPLE: return {31'd0, $signed(a) <= $signed(b)};
            default:             return {31'd0, $signed(a) < $signed(b)};
        endcase
    endfunction

    function automatic bces_pkg::out_item_t predict_step(bces_pkg::in_item_t it);
        bces_pkg::out_item_t o;
        logic [31:0] imm, old, a, tmask;
        o = '0;
        imm = {{16{it.immediate[15]}}, it.immediate};
        if (it.clock_irq) clk_pend = 1'b1;
        if (it.req_type) begin
            if (ld_wait) begin
                wr_reg(ld_tgt, it.load_data);
                ld_wait = 1'b0;
                take_irq(it.keyboard_irq);
            end
        end else if (!ld_wait && !halt_f) begin
            pc = pc + bces_pkg::PC_STEP;
            old = pc;
            a = rd_reg(it.src_a);
            tmask = bces_pkg::JUMP_MASK | (old & bces_pkg::SUP_BIT);
            if (it.opcode < bces_pkg::OP_ALU_END) begin
                wr_reg(it.dest_c, alu_result(it.opcode[4:1], a,
                                             it.opcode[0] ? imm : rd_reg(it.src_b)));
            end else if (it.opcode == bces_pkg::OP_JMP) begin
                pc = a & tmask;
                wr_reg(it.dest_c, old);
            end else if (it.opcode == bces_pkg::OP_BT || it.opcode == bces_pkg::OP_BF) begin
                if ((a != 32'd0) == (it.opcode == bces_pkg::OP_BT))
                    pc = (old + (imm << 2)) & tmask;
                wr_reg(it.dest_c, old);
            end else if (it.opcode == bces_pkg::OP_LD || it.opcode == bces_pkg::OP_LDR) begin
                o.mem_request = bces_pkg::MEM_READ;
                o.mem_address = (it.opcode == bces_pkg::OP_LD) ? a + imm : old + (imm << 2);
                ld_wait = 1'b1;
                ld_tgt = it.dest_c;
            end else if (it.opcode == bces_pkg::OP_ST) begin
                o.mem_request = bces_pkg::MEM_WRITE;
                o.mem_address = a + imm;
                o.mem_write_data = rd_reg(it.dest_c);
            end else if (it.opcode == bces_pkg::OP_SCALL && old[31]) begin
                if ($unsigned(it.immediate) == bces_pkg::CO_HALT) begin
                    halt_f = 1'b1;
                end else if ($unsigned(it.immediate) == bces_pkg::CO_RDCH) begin
                    gpr[0] = {24'd0, it.console_char};
                    o.char_taken = 1'b1;
                end else if ($unsigned(it.immediate) == bces_pkg::CO_WRCH) begin
                    o.char_out_valid = 1'b1;
                    o.char_out = gpr[0][7:0];
                end
            end else begin
                // illegal opcode or callout from user mode
                wr_reg(5'(EXC_REG), old);
                pc = vec_ill;
            end
            if (!ld_wait) take_irq(it.keyboard_irq);
        end
        o.next_pc = pc;
        o.pc_valid = !ld_wait;
        o.halted = halt_f;
        return o;
    endfunction

    task automatic send_item(bces_pkg::in_item_t it);
        int gap;
        gap = 0;
        while (gap < 20 && $urandom_range(99) < tx_idle) gap++;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_item <= it;
        do @(posedge aclk); while (!s_ready);
        exp_results.push_back(predict_step(it));
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (exp_results.size() != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
    endtask

    task automatic write_cfg(logic [1:0] idx, logic [31:0] val);
        drain();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            bces_pkg::CFG_RESET_VEC: vec_reset = val;  // takes effect only at a reset
            bces_pkg::CFG_ILL_VEC:   vec_ill = val;
            bces_pkg::CFG_CLK_VEC:   vec_clk = val;
            default:                 vec_kbd = val;
        endcase
    endtask

    function automatic bces_pkg::in_item_t exec_item(logic [5:0] op, logic [4:0] ra,
                                                     logic [4:0] rb, logic [4:0] rc,
                                                     logic [15:0] imm);
        bces_pkg::in_item_t it;
        it = '0;
        it.opcode = op;
        it.src_a = ra;
        it.src_b = rb;
        it.dest_c = rc;
        it.immediate = imm;
        return it;
    endfunction

    // fills a register through a load and its return item
    task automatic load_reg(logic [4:0] rc, logic [31:0] val);
        bces_pkg::in_item_t it;
        send_item(exec_item(bces_pkg::OP_LD, 5'd31, 5'd0, rc, 16'h0040));
        it = '0;
        it.req_type = 1'b1;
        it.load_data = val;
        send_item(it);
    endtask

    function automatic bces_pkg::in_item_t random_item();
        bces_pkg::in_item_t it;
        it.req_type = 1'b0;
        it.opcode = ($urandom_range(99) < 6) ? 6'($urandom_range(63, 33))
                                             : 6'($urandom_range(32));
        it.src_a = 5'($urandom);
        it.src_b = 5'($urandom);
        it.dest_c = 5'($urandom);
        it.immediate = 16'($urandom);
        it.load_data = $urandom;
        it.console_char = 8'($urandom);
        it.clock_irq = ($urandom_range(99) < 5);
        it.keyboard_irq = ($urandom_range(99) < 8);
        // keep the halt callout for the closing test
        if (it.opcode == bces_pkg::OP_SCALL && $unsigned(it.immediate) == bces_pkg::CO_HALT)
            it.immediate = 16'($urandom_range(3, 1));
        return it;
    endfunction

    task automatic test_alu_extremes();
        load_reg(5'd1, 32'h8000_0000);
        load_reg(5'd2, 32'hFFFF_FFFF);
        load_reg(5'd3, 32'h7FFF_FFFF);
        // most negative by minus one
        send_item(exec_item(alu_opcode(bces_pkg::ALU_DIV, 1'b0), 5'd1, 5'd2, 5'd4, 16'd0));
        // divide by zero
        send_item(exec_item(alu_opcode(bces_pkg::ALU_DIV, 1'b0), 5'd1, 5'd31, 5'd5, 16'd0));
        send_item(exec_item(alu_opcode(bces_pkg::ALU_DIV, 1'b1), 5'd3, 5'd0, 5'd6, 16'h8000));
        for (int op = 0; op < 26; op += 2)
            send_item(exec_item(6'(op), 5'd1, 5'd3, 5'(7 + op / 2), 16'd0));
        for (int op = 1; op < 26; op += 2)
            send_item(exec_item(6'(op), 5'd2, 5'd0, 5'd31, (op & 2) ? 16'h7FFF : 16'h8000));
    endtask

    task automatic test_memory();
        bces_pkg::in_item_t it;
        send_item(exec_item(bces_pkg::OP_ST, 5'd3, 5'd0, 5'd1, 16'hFFFC));
        send_item(exec_item(bces_pkg::OP_LDR, 5'd0, 5'd0, 5'd9, 16'h7FFF));
        // stalled behind the load
        send_item(exec_item(alu_opcode(bces_pkg::ALU_ADD, 1'b0), 5'd1, 5'd1, 5'd10, 16'd0));
        it = '0;
        it.req_type = 1'b1;
        it.load_data = 32'hA5A5_5A5A;
        send_item(it);
        send_item(it);                                          // stray load return
    endtask

    task automatic test_callouts();
        bces_pkg::in_item_t it;
        it = exec_item(bces_pkg::OP_SCALL, 5'd0, 5'd0, 5'd0, bces_pkg::CO_RDCH);
        it.console_char = 8'hFF;
        send_item(it);
        send_item(exec_item(bces_pkg::OP_SCALL, 5'd7, 5'd0, 5'd0, bces_pkg::CO_WRCH));
        send_item(exec_item(bces_pkg::OP_SCALL, 5'd0, 5'd0, 5'd0, 16'd5));
        send_item(exec_item(OP_ILLEGAL, 5'd0, 5'd0, 5'd0, 16'd0));
    endtask

    task automatic test_user_mode();
        bces_pkg::in_item_t it;
        load_reg(5'd11, 32'h1234_5679);
        send_item(exec_item(bces_pkg::OP_JMP, 5'd11, 5'd0, 5'd12, 16'd0));
        send_item(exec_item(bces_pkg::OP_SCALL, 5'd0, 5'd0, 5'd0, bces_pkg::CO_WRCH));
        send_item(exec_item(bces_pkg::OP_JMP, 5'd11, 5'd0, 5'd12, 16'd0));
        send_item(exec_item(bces_pkg::OP_BT, 5'd11, 5'd0, 5'd13, 16'h8000));
        send_item(exec_item(bces_pkg::OP_BF, 5'd11, 5'd0, 5'd13, 16'h0010));
        it = exec_item(alu_opcode(bces_pkg::ALU_ADD, 1'b1), 5'd0, 5'd0, 5'd14, 16'd1);
        it.clock_irq = 1'b1;
        it.keyboard_irq = 1'b1;
        send_item(it);
        send_item(exec_item(bces_pkg::OP_JMP, 5'd11, 5'd0, 5'd12, 16'd0));
        it.clock_irq = 1'b0;
        send_item(it);
    endtask

    task automatic test_random(int n);
        bces_pkg::in_item_t it;
        for (int i = 0; i < n; i++) begin
            it = random_item();
            case ($urandom_range(99)) inside
                [0:9]: begin
                    // load, maybe stalled instructions, then its return
                    it.opcode = $urandom_range(1) ? bces_pkg::OP_LD : bces_pkg::OP_LDR;
                    send_item(it);
                    repeat ($urandom_range(2)) send_item(random_item());
                    it = random_item();
                    it.req_type = 1'b1;
                    send_item(it);
                end
                [10:14]: begin
                    it.req_type = 1'b1;
                    send_item(it);
                end
                [15:20]: begin
                    // maybe get into user mode through a random target
                    load_reg(5'd20, $urandom);
                    it.opcode = bces_pkg::OP_JMP;
                    it.src_a = 5'd20;
                    send_item(it);
                end
                default: send_item(it);
            endcase
        end
    endtask

    task automatic test_backpressure();
        hold_req++;
        test_random(30);
        drain();
        test_random(10);
    endtask

    task automatic test_halt();
        bces_pkg::in_item_t it;
        drain();
        send_item(exec_item(bces_pkg::OP_JMP, 5'd31, 5'd0, 5'd0, 16'd0));
        // illegal in user mode
        send_item(exec_item(bces_pkg::OP_SCALL, 5'd0, 5'd0, 5'd0, bces_pkg::CO_HALT));
        send_item(exec_item(bces_pkg::OP_SCALL, 5'd0, 5'd0, 5'd0, bces_pkg::CO_HALT));
        it = random_item();
        it.clock_irq = 1'b1;
        send_item(it);
        send_item(random_item());
    endtask

    // receiver side, a new hold request starts a long stretch of not ready
    always @(posedge aclk) begin
        if (hold_req != hold_seen) begin
            hold_seen <= hold_req;
            hold_left <= 400;
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            m_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else begin
            m_ready <= ($urandom_range(99) >= rx_idle);
        end
    end

    always @(posedge aclk) begin
        bces_pkg::out_item_t e;
        if (aresetn && m_valid && m_ready) begin
            if (exp_results.size() == 0) begin
                report("result item with nothing expected");
            end else begin
                e = exp_results.pop_front();
                if (m_item.next_pc != e.next_pc)
                    report($sformatf("next_pc %h exp %h", m_item.next_pc, e.next_pc));
                if (m_item.pc_valid != e.pc_valid) report("pc_valid");
                if (m_item.mem_request != e.mem_request) report("mem_request");
                if (m_item.mem_address != e.mem_address)
                    report($sformatf("mem_address %h exp %h", m_item.mem_address,
                                     e.mem_address));
                if (m_item.mem_write_data != e.mem_write_data) report("mem_write_data");
                if (m_item.char_out_valid != e.char_out_valid) report("char_out_valid");
                if (m_item.char_out != e.char_out) report("char_out");
                if (m_item.char_taken != e.char_taken) report("char_taken");
                if (m_item.halted != e.halted) report("halted");
            end
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAIL beta_cpu_execute_step_unit");
            $finish;
        end
    end

    initial begin
        for (int i = 0; i < 32; i++) gpr[i] = '0;
        vec_reset = 32'h8000_0000;
        vec_ill = 32'h8000_0004;
        vec_clk = 32'h8000_0008;
        vec_kbd = 32'h8000_000C;
        pc = vec_reset;
        clk_pend = 1'b0;
        halt_f = 1'b0;
        ld_wait = 1'b0;
        ld_tgt = '0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        tx_idle = 38;
        rx_idle = 73;
        test_alu_extremes();
        test_memory();
        test_callouts();
        test_user_mode();
        test_random(160);
        write_cfg(bces_pkg::CFG_RESET_VEC, 32'hFFFF_FFFF);
        write_cfg(bces_pkg::CFG_ILL_VEC, 32'h0000_0000);
        write_cfg(bces_pkg::CFG_CLK_VEC, 32'hFFFF_FFFF);
        write_cfg(bces_pkg::CFG_KBD_VEC, 32'h0000_0000);
        tx_idle = 73;
        rx_idle = 38;
        test_random(160);
        test_backpressure();
        write_cfg(bces_pkg::CFG_ILL_VEC, $urandom);
        write_cfg(bces_pkg::CFG_CLK_VEC, $urandom & 32'h7FFF_FFFF);
        write_cfg(bces_pkg::CFG_KBD_VEC, $urandom | 32'h8000_0000);
        write_cfg(bces_pkg::CFG_RESET_VEC, 32'h0000_0000);
        tx_idle = 0;
        rx_idle = 0;
        test_random(200);
        test_halt();

        drain();
        if (errors == 0) begin
            $display("PASS beta_cpu_execute_step_unit");
        end else begin
            $display("FAIL beta_cpu_execute_step_unit");
        end
        $finish;
    end
endmodule
